### rtl/core/mck_pkg.sv
`default_nettype none
package mck_pkg;

    localparam int unsigned CharW = 8;
    localparam int unsigned ShownW = 7;
    localparam int unsigned DotW = 11;
    localparam int unsigned DurW = 13;
    localparam int unsigned CodeW = 6;
    localparam int unsigned LenW = 3;
    localparam logic [DotW-1:0] DotReset = 11'd60;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ON,
        S_OFF,
        S_GAP,
        S_SPACE
    } t_step;

    typedef enum logic [1:0] {
        C_IN,
        C_DEC,
        C_OUT,
        C_LOOP
    } t_cond;

    typedef enum logic [1:0] {
        D_ONE,
        D_TWO,
        D_ELEM,
        D_FOUR
    } t_dur;

    typedef enum logic [1:0] {
        K_NONE,
        K_SPACE,
        K_CODE
    } t_kind;

    typedef struct packed {
        logic  take;
        logic  emit;
        logic  key;
        t_dur  dur;
        logic  last;
        logic  adv;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_kind kind;
        logic  more;
    } t_dp_stat;

    typedef struct packed {
        t_kind             kind;
        logic [LenW-1:0]   len;
        logic [CodeW-1:0]  bits;
    } t_code;

    // control store: one word per step
    function automatic t_uword mck_ucode(input t_step s);
        t_uword w;
        w = '{take: 1'b0, emit: 1'b0, key: 1'b0, dur: D_ONE, last: 1'b0,
              adv: 1'b0, cond: C_IN, target: S_IDLE};
        case (s)
            S_IDLE: begin
                w.take = 1'b1;
                w.cond = C_IN;
                w.target = S_DECODE;
            end
            S_DECODE: begin
                w.cond = C_DEC;
                w.target = S_SPACE;
            end
            S_ON: begin
                w.emit = 1'b1;
                w.key = 1'b1;
                w.dur = D_ELEM;
                w.cond = C_OUT;
                w.target = S_OFF;
            end
            S_OFF: begin
                w.emit = 1'b1;
                w.dur = D_ONE;
                w.adv = 1'b1;
                w.cond = C_LOOP;
                w.target = S_ON;
            end
            S_GAP: begin
                w.emit = 1'b1;
                w.dur = D_TWO;
                w.last = 1'b1;
                w.cond = C_OUT;
                w.target = S_IDLE;
            end
            S_SPACE: begin
                w.emit = 1'b1;
                w.dur = D_FOUR;
                w.last = 1'b1;
                w.cond = C_OUT;
                w.target = S_IDLE;
            end
            default: begin
                w.cond = C_OUT;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    // upper-case fold, newline sent as '='
    function automatic logic [CharW-1:0] mck_fold(input logic [CharW-1:0] c);
        logic [CharW-1:0] r;
        r = c;
        if (c inside {["a":"z"]}) begin
            r = c - 8'd32;
        end else if (c == 8'h0A) begin
            r = "=";
        end
        return r;
    endfunction

    // elements left aligned, first element in the msb, 1 = dah
    function automatic t_code mck_lookup(input logic [CharW-1:0] c);
        t_code r;
        r = '{kind: K_CODE, len: 3'd0, bits: 6'b000000};
        case (c)
            "A": begin r.len = 3'd2; r.bits = 6'b010000; end
            "B": begin r.len = 3'd4; r.bits = 6'b100000; end
            "C": begin r.len = 3'd4; r.bits = 6'b101000; end
            "D": begin r.len = 3'd3; r.bits = 6'b100000; end
            "E": begin r.len = 3'd1; r.bits = 6'b000000; end
            "F": begin r.len = 3'd4; r.bits = 6'b001000; end
            "G": begin r.len = 3'd3; r.bits = 6'b110000; end
            "H": begin r.len = 3'd4; r.bits = 6'b000000; end
            "I": begin r.len = 3'd2; r.bits = 6'b000000; end
            "J": begin r.len = 3'd4; r.bits = 6'b011100; end
            "K": begin r.len = 3'd3; r.bits = 6'b101000; end
            "L": begin r.len = 3'd4; r.bits = 6'b010000; end
            "M": begin r.len = 3'd2; r.bits = 6'b110000; end
            "N": begin r.len = 3'd2; r.bits = 6'b100000; end
            "O": begin r.len = 3'd3; r.bits = 6'b111000; end
            "P": begin r.len = 3'd4; r.bits = 6'b011000; end
            "Q": begin r.len = 3'd4; r.bits = 6'b110100; end
            "R": begin r.len = 3'd3; r.bits = 6'b010000; end
            "S": begin r.len = 3'd3; r.bits = 6'b000000; end
            "T": begin r.len = 3'd1; r.bits = 6'b100000; end
            "U": begin r.len = 3'd3; r.bits = 6'b001000; end
            "V": begin r.len = 3'd4; r.bits = 6'b000100; end
            "W": begin r.len = 3'd3; r.bits = 6'b011000; end
            "X": begin r.len = 3'd4; r.bits = 6'b100100; end
            "Y": begin r.len = 3'd4; r.bits = 6'b101100; end
            "Z": begin r.len = 3'd4; r.bits = 6'b110000; end
            "1": begin r.len = 3'd5; r.bits = 6'b011110; end
            "2": begin r.len = 3'd5; r.bits = 6'b001110; end
            "3": begin r.len = 3'd5; r.bits = 6'b000110; end
            "4": begin r.len = 3'd5; r.bits = 6'b000010; end
            "5": begin r.len = 3'd5; r.bits = 6'b000000; end
            "6": begin r.len = 3'd5; r.bits = 6'b100000; end
            "7": begin r.len = 3'd5; r.bits = 6'b110000; end
            "8": begin r.len = 3'd5; r.bits = 6'b111000; end
            "9": begin r.len = 3'd5; r.bits = 6'b111100; end
            "0": begin r.len = 3'd5; r.bits = 6'b111110; end
            ".": begin r.len = 3'd6; r.bits = 6'b010101; end
            ",": begin r.len = 3'd6; r.bits = 6'b110011; end
            "?": begin r.len = 3'd6; r.bits = 6'b001100; end
            "/": begin r.len = 3'd5; r.bits = 6'b100100; end
            "-": begin r.len = 3'd6; r.bits = 6'b100001; end
            "=": begin r.len = 3'd5; r.bits = 6'b100010; end
            "!": begin r.len = 3'd6; r.bits = 6'b101011; end
            " ": r.kind = K_SPACE;
            default: r.kind = K_NONE;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/mck_if.sv
`default_nettype none
interface mck_char_if import mck_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface mck_seg_if import mck_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              key_down;
    logic [DurW-1:0]   duration_ms;
    logic [ShownW-1:0] shown_char;
    logic              last;

    modport source (output valid, output key_down, output duration_ms,
                    output shown_char, output last, input ready);
    modport sink (input valid, input key_down, input duration_ms,
                  input shown_char, input last, output ready);
endinterface
`default_nettype wire

### rtl/core/mck_sequencer.sv
`default_nettype none
module mck_sequencer import mck_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_fire,
    input  wire logic     i_out_fire,
    input  wire t_dp_stat i_stat,
    output t_uword        o_uword
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;

    assign w_uw = mck_ucode(r_step);
    assign o_uword = w_uw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        n_step = r_step;
        case (w_uw.cond)
            C_IN: begin
                if (i_in_fire) n_step = w_uw.target;
            end
            C_DEC: begin
                case (i_stat.kind)
                    K_CODE:  n_step = t_step'(r_step + 3'd1);
                    K_SPACE: n_step = w_uw.target;
                    default: n_step = S_IDLE;
                endcase
            end
            C_OUT: begin
                if (i_out_fire) n_step = w_uw.target;
            end
            C_LOOP: begin
                // back to the next element, else fall through to the letter gap
                if (i_out_fire) begin
                    n_step = i_stat.more ? w_uw.target : t_step'(r_step + 3'd1);
                end
            end
            default: n_step = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/mck_datapath.sv
`default_nettype none
module mck_datapath import mck_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_uword            i_uword,
    input  wire logic              i_in_fire,
    input  wire logic              i_out_fire,
    input  wire logic [CharW-1:0]  i_char_code,
    input  wire logic [DotW-1:0]   i_dot_time_ms,
    output t_dp_stat               o_stat,
    output logic                   o_key_down,
    output logic [DurW-1:0]        o_duration_ms,
    output logic [ShownW-1:0]      o_shown_char,
    output logic                   o_last
);

    logic [CharW-1:0] r_char;
    t_kind            r_kind;
    logic [LenW-1:0]  r_left;
    logic [CodeW-1:0] r_bits;
    t_code            w_code;
    logic [DurW-1:0]  w_dot;

    assign w_code = mck_lookup(r_char);

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_char <= mck_fold(i_char_code);
        end
        if (i_uword.cond == C_DEC) begin
            r_kind <= w_code.kind;
            r_left <= w_code.len;
            r_bits <= w_code.bits;
        end else if (i_out_fire && i_uword.adv) begin
            r_left <= r_left - 3'd1;
            r_bits <= {r_bits[CodeW-2:0], 1'b0};
        end
    end

    assign o_stat.kind = (i_uword.cond == C_DEC) ? w_code.kind : r_kind;
    assign o_stat.more = (r_left > 3'd1);

    // zero dot time counts as one ms
    assign w_dot = (i_dot_time_ms == '0) ? DurW'(1) : DurW'(i_dot_time_ms);

    always_comb begin
        case (i_uword.dur)
            D_ONE:   o_duration_ms = w_dot;
            D_TWO:   o_duration_ms = {w_dot[DurW-2:0], 1'b0};
            D_ELEM:  o_duration_ms = r_bits[CodeW-1] ? (w_dot + {w_dot[DurW-2:0], 1'b0})
                                                     : w_dot;
            D_FOUR:  o_duration_ms = {w_dot[DurW-3:0], 2'b00};
            default: o_duration_ms = w_dot;
        endcase
    end

    assign o_key_down = i_uword.key;
    assign o_last = i_uword.last;
    assign o_shown_char = r_char[ShownW-1:0];

endmodule
`default_nettype wire

### rtl/core/morse_code_keyer_top.sv
`default_nettype none
// morse keyer: one text byte in on i_char, key segments out on o_seg.
// each segment carries key on/off, its length in ms, the upper-case
// character being sent and a last flag on the closing segment.
// a letter of n elements gives 2n+1 segments; a space gives one; carriage
// return and characters outside the table give none.
// a byte is taken in the idle step and decoded in the next cycle, then one
// segment is offered per cycle while the receiver does not stall, as the
// control store steps through one segment per step.
// i_char.ready is high only while the sequencer waits in its idle step.
// a stalled o_seg holds the segment steady until it is taken, unless the dot time is written meanwhile.
// reset returns the sequencer to idle and the dot time to 60 ms; the
// dot time register is written whenever i_cfg_wr_en is high, and a dot
// time of zero is sent as 1 ms.
module morse_code_keyer_top import mck_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [DotW-1:0] i_cfg_wr_data,
    mck_char_if.sink             i_char,
    mck_seg_if.source            o_seg
);

    logic [DotW-1:0] r_dot;
    t_uword          w_uw;
    t_dp_stat        w_stat;
    logic            w_in_fire;
    logic            w_out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= DotReset;
        end else if (i_cfg_wr_en) begin
            r_dot <= i_cfg_wr_data;
        end
    end

    assign i_char.ready = w_uw.take;
    assign o_seg.valid = w_uw.emit;
    assign w_in_fire = i_char.valid && w_uw.take;
    assign w_out_fire = w_uw.emit && o_seg.ready;

    mck_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_out_fire (w_out_fire),
        .i_stat     (w_stat),
        .o_uword    (w_uw)
    );

    mck_datapath u_dp (
        .i_clk         (i_clk),
        .i_uword       (w_uw),
        .i_in_fire     (w_in_fire),
        .i_out_fire    (w_out_fire),
        .i_char_code   (i_char.char_code),
        .i_dot_time_ms (r_dot),
        .o_stat        (w_stat),
        .o_key_down    (o_seg.key_down),
        .o_duration_ms (o_seg.duration_ms),
        .o_shown_char  (o_seg.shown_char),
        .o_last        (o_seg.last)
    );

    a_no_take_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_uw.emit |-> !w_uw.take)
        else $error("input ready while a segment is offered");

    a_decode_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_seg.valid)
        else $error("segment offered in the decode step");

    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_seg.last) |=> i_char.ready)
        else $error("not idle after the closing segment");

    a_on_then_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_seg.key_down) |=> (o_seg.valid && !o_seg.key_down))
        else $error("key-down segment not followed by key-up");

endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
module testbench import mck_pkg::*; ();

    localparam logic [CharW-1:0] ChCr = 8'h0D;
    localparam logic [CharW-1:0] ChLf = 8'h0A;
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] CaseOffset = 8'd32;
    localparam int SettleCycles = 6;
    localparam int PressureCycles = 300;
    localparam int RandomTarget = 400;

    typedef struct packed {
        logic              key;
        logic [DurW-1:0]   dur;
        logic [ShownW-1:0] shown;
        logic              fin;
    } t_seg;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [DotW-1:0] i_cfg_wr_data;

    mck_char_if chr ();
    mck_seg_if seg ();

    morse_code_keyer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char        (chr),
        .o_seg         (seg)
    );

    t_seg keyed_segs[$];
    logic [DotW-1:0] dot_ms;
    int errors;
    int chars_sent;
    int chars_keyed;
    int segs_checked;
    int dot_writes;
    bit full_rate;
    bit pressure_req;
    string sign_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?/-=!";

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic string morse_of(input logic [CharW-1:0] c);
        case (c)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "1": return ".----";  "2": return "..---";  "3": return "...--";
            "4": return "....-";  "5": return ".....";  "6": return "-....";
            "7": return "--...";  "8": return "---..";  "9": return "----.";
            "0": return "-----";
            ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
            "/": return "-..-.";  "-": return "-....-"; "=": return "-...-";
            "!": return "-.-.--";
            default: return "";
        endcase
    endfunction

    function automatic void push_seg(input logic key, input logic [DurW-1:0] dur,
                                     input logic [CharW-1:0] c, input logic fin);
        t_seg s;
        s.key = key;
        s.dur = dur;
        s.shown = c[ShownW-1:0];
        s.fin = fin;
        keyed_segs.push_back(s);
    endfunction

    // queues the segments one byte keys out, returns how many
    function automatic int key_char(input logic [CharW-1:0] c);
        logic [CharW-1:0] up;
        logic [DurW-1:0] dot;
        string pat;
        up = c;
        dot = (dot_ms == '0) ? DurW'(1) : DurW'(dot_ms);
        if (c >= "a" && c <= "z") begin
            up = c - CaseOffset;
        end
        if (up == ChCr) begin
            return 0;
        end
        if (up == ChLf) begin
            up = "=";
        end else if (up == ChSpace) begin
            push_seg(1'b0, DurW'(dot * 4), up, 1'b1);
            return 1;
        end
        pat = morse_of(up);
        if (pat.len() == 0) begin
            return 0;
        end
        for (int i = 0; i < pat.len(); i++) begin
            push_seg(1'b1, (pat[i] == "-") ? DurW'(dot * 3) : dot, up, 1'b0);
            push_seg(1'b0, dot, up, 1'b0);
        end
        push_seg(1'b0, DurW'(dot * 2), up, 1'b1);
        return 2 * pat.len() + 1;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_rate || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_char(input logic [CharW-1:0] c);
        int gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            chr.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        chr.valid <= 1'b1;
        chr.char_code <= c;
        do begin
            @(posedge i_clk);
        end while (chr.ready !== 1'b1);
        chars_sent++;
        if (key_char(c) > 0) begin
            chars_keyed++;
        end
    endtask

    // stop offering, drain every queued segment, then let the decode step finish
    task automatic drain();
        @(negedge i_clk);
        chr.valid <= 1'b0;
        while (keyed_segs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_dot_time(input logic [DotW-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dot_ms = v;
        dot_writes++;
    endtask

    function automatic logic [CharW-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return sign_set[$urandom_range(0, sign_set.len() - 1)];
        end else if (r < 70) begin
            return "a" + CharW'($urandom_range(0, 25));
        end else if (r < 78) begin
            return ChSpace;
        end else if (r < 83) begin
            return ChLf;
        end else if (r < 86) begin
            return ChCr;
        end
        return CharW'($urandom_range(0, 255));
    endfunction

    // receiver: random stalls, plus one long hold on request
    initial begin
        int stall;
        int r;
        stall = 0;
        seg.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                stall = PressureCycles;
            end
            if (stall > 0) begin
                stall--;
                seg.ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (full_rate || r < 70) begin
                    seg.ready <= 1'b1;
                end else begin
                    seg.ready <= 1'b0;
                    stall = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_seg got;
        t_seg want;
        if (i_rst_n && seg.valid === 1'b1 && seg.ready === 1'b1) begin
            got = '{key: seg.key_down, dur: seg.duration_ms, shown: seg.shown_char,
                    fin: seg.last};
            if (keyed_segs.size() == 0) begin
                $display("%0t: unexpected segment key %0b dur %0d char %0d last %0b",
                         $time, got.key, got.dur, got.shown, got.fin);
                errors++;
            end else begin
                want = keyed_segs.pop_front();
                segs_checked++;
                if (got.key !== want.key || got.dur !== want.dur ||
                    got.shown !== want.shown || got.fin !== want.fin) begin
                    $display("%0t: segment mismatch, expected key %0b dur %0d char %0d last %0b",
                             $time, want.key, want.dur, want.shown, want.fin);
                    $display("%0t:                  got      key %0b dur %0d char %0d last %0b",
                             $time, got.key, got.dur, got.shown, got.fin);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [CharW-1:0] picks[$];
        picks = '{"E", "T", ".", ",", "?", "-", "!", "/", "=", "a", "z", ChLf, ChCr,
                  ChSpace, 8'h00, 8'h7F, 8'h80, 8'hFF, "@", "A", "Z", "0", "9"};
        foreach (picks[i]) begin
            send_char(picks[i]);
        end
        drain();
    endtask

    task automatic test_dot_extremes();
        set_dot_time('0);
        send_char("e");
        set_dot_time('1);
        send_char("T");
        set_dot_time({DotW{1'b1}});
        send_char(ChSpace);
        send_char("-");
        set_dot_time(11'd1200);
        send_char("0");
        drain();
    endtask

    task automatic test_random();
        int phase;
        int start;
        logic [DotW-1:0] v;
        phase = 0;
        start = chars_sent;
        while (chars_sent - start < RandomTarget) begin
            case (phase % 4)
                0: v = DotW'($urandom_range(1, 1200));
                1: v = DotW'($urandom_range(1, 20));
                2: v = DotW'($urandom_range(0, 2047));
                default: v = DotW'($urandom_range(1000, 1200));
            endcase
            set_dot_time(v);
            full_rate = (phase == 2);
            repeat (80) begin
                send_char(random_char());
            end
            full_rate = 1'b0;
            phase++;
        end
        drain();
    endtask

    task automatic test_backpressure();
        set_dot_time(DotReset);
        pressure_req = 1'b1;
        repeat (12) begin
            send_char(sign_set[$urandom_range(0, sign_set.len() - 1)]);
        end
        drain();
    endtask

    initial begin
        errors = 0;
        chars_sent = 0;
        chars_keyed = 0;
        segs_checked = 0;
        dot_writes = 0;
        full_rate = 1'b0;
        pressure_req = 1'b0;
        dot_ms = DotReset;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        chr.valid = 1'b0;
        chr.char_code = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_dot_extremes();
        test_random();
        test_backpressure();

        drain();
        repeat (20) @(posedge i_clk);
        if (keyed_segs.size() != 0) begin
            $display("%0t: %0d segments never arrived", $time, keyed_segs.size());
            errors++;
        end
        $display("sent %0d bytes (%0d keyed), checked %0d segments, %0d dot time writes",
                 chars_sent, chars_keyed, segs_checked, dot_writes);
        $display("covered the full sign table, case fold, newline, space, ignored bytes,");
        $display("dot times 0 to 2047 and a long output stall with input backed up");
        if (errors == 0) begin
            $display("morse_code_keyer_top regression: pass");
        end else begin
            $display("morse_code_keyer_top regression: fail");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("morse_code_keyer_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
rtl/core/mck_pkg.sv
rtl/core/mck_if.sv
rtl/core/mck_sequencer.sv
rtl/core/mck_datapath.sv
rtl/core/morse_code_keyer_top.sv
bench/testbench.sv
